>>> rtl/circle_vertex_generator_macros.svh
// assertion helpers for the circle vertex generator
`ifndef CIRCLE_VERTEX_GENERATOR_MACROS_SVH
`define CIRCLE_VERTEX_GENERATOR_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define CVG_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("cvg check failed");

// clocked assertion that is also checked during reset
`define CVG_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("cvg check failed");

`endif

>>> rtl/cvg_pkg.sv
`timescale 1ns / 1ps
package cvg_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW = 33;
  localparam int unsigned SegW = 7;
  localparam logic [SegW-1:0] SegReset = 7'd12;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic [3:0] LastTerm = 4'd13;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [RadW-1:0] r;
  } cvg_job_t;

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_ROOT, F_PUSH} cvg_front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV, B_VSET, B_XS, B_TA, B_TB, B_TC, B_CLAMP,
    B_PX, B_FX, B_PY, B_FY, B_OUT
  } cvg_back_state_t;

  // floor(2^32 / k) for the taylor term divisors
  function automatic logic [32:0] recip(input logic [3:0] k);
    logic [32:0] v;
    unique case (k)
      4'd1: v = 33'd4294967296;
      4'd2: v = 33'd2147483648;
      4'd3: v = 33'd1431655765;
      4'd4: v = 33'd1073741824;
      4'd5: v = 33'd858993459;
      4'd6: v = 33'd715827882;
      4'd7: v = 33'd613566756;
      4'd8: v = 33'd536870912;
      4'd9: v = 33'd477218588;
      4'd10: v = 33'd429496729;
      4'd11: v = 33'd390451572;
      4'd12: v = 33'd357913941;
      4'd13: v = 33'd330382099;
      default: v = 33'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/cvg_front.sv
`timescale 1ns / 1ps
module cvg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  center_x,
  input  logic signed [31:0]  center_y,
  input  logic signed [31:0]  rim_x,
  input  logic signed [31:0]  rim_y,
  output logic                push,
  output cvg_pkg::cvg_job_t   push_job,
  input  logic                fifo_full
);

  cvg_pkg::cvg_front_state_t state_r, state_nxt;
  logic signed [31:0] cx_r, cy_r;
  logic [32:0] ax_r, ay_r, root_r;
  logic [65:0] acc_r;
  logic [35:0] rem_r;
  logic [5:0]  cnt_r;

  logic signed [32:0] dx, dy;
  logic [1:0]  pair;
  logic [35:0] rem_s, trial;
  logic [65:0] addx, addy;

  assign dx = 33'(rim_x) - 33'(center_x);
  assign dy = 33'(rim_y) - 33'(center_y);
  assign addx = ax_r[cnt_r] ? (66'(ax_r) << cnt_r) : 66'd0;
  assign addy = ay_r[cnt_r] ? (66'(ay_r) << cnt_r) : 66'd0;
  assign pair = 2'(acc_r >> {cnt_r, 1'b0});
  assign rem_s = {rem_r[33:0], pair};
  assign trial = {1'b0, root_r, 2'b01};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cvg_pkg::F_IDLE: if (in_valid) state_nxt = cvg_pkg::F_SQ;
      cvg_pkg::F_SQ:   if (cnt_r == 6'd32) state_nxt = cvg_pkg::F_ROOT;
      cvg_pkg::F_ROOT: if (cnt_r == 6'd0) state_nxt = cvg_pkg::F_PUSH;
      cvg_pkg::F_PUSH: if (!fifo_full) state_nxt = cvg_pkg::F_IDLE;
      default: state_nxt = cvg_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == cvg_pkg::F_IDLE);
    push = (state_r == cvg_pkg::F_PUSH) && !fifo_full;
    push_job.cx = cx_r;
    push_job.cy = cy_r;
    push_job.r = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cvg_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      cvg_pkg::F_IDLE: begin
        cx_r <= center_x;
        cy_r <= center_y;
        ax_r <= dx[32] ? 33'(-dx) : 33'(dx);
        ay_r <= dy[32] ? 33'(-dy) : 33'(dy);
        acc_r <= '0;
        cnt_r <= '0;
      end
      cvg_pkg::F_SQ: begin
        // sum of squares, one multiplier bit of each per cycle
        acc_r <= acc_r + addx + addy;
        if (cnt_r == 6'd32) begin
          root_r <= '0;
          rem_r <= '0;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
      cvg_pkg::F_ROOT: begin
        if (rem_s >= trial) begin
          rem_r <= rem_s - trial;
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          rem_r <= rem_s;
          root_r <= {root_r[31:0], 1'b0};
        end
        if (cnt_r != 6'd0) cnt_r <= cnt_r - 6'd1;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/cvg_fifo.sv
`timescale 1ns / 1ps
module cvg_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cvg_pkg::cvg_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output cvg_pkg::cvg_job_t head
);

  cvg_pkg::cvg_job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/cvg_back.sv
`timescale 1ns / 1ps
module cvg_back #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [6:0]        seg_count,
  input  logic              empty,
  input  cvg_pkg::cvg_job_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       vertex_x,
  output logic [31:0]       vertex_y,
  output logic              last_vertex
);

  localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [6:0] MaxSeg = 7'(MAX_SEGMENTS);

  cvg_pkg::cvg_back_state_t state_r, state_nxt;
  logic signed [31:0] cx_r, cy_r;
  logic [32:0] r_r;
  logic [6:0]  n_r, prem_r;
  logic [IW-1:0] i_r;
  logic [32:0] phase_r, dq_r;
  logic [7:0]  drem_r;
  logic [5:0]  dcnt_r;
  logic        swap_r;
  logic [1:0]  quad_r;
  logic [30:0] x_r, t_r, u_r;
  logic [3:0]  k_r;
  logic signed [33:0] sn_r, cs_r;
  logic [63:0] prod_r;
  logic signed [31:0] vc_r, vs_r, vx_r;
  logic        out_valid_r, out_last_r;
  logic [31:0] out_x_r, out_y_r;

  logic [6:0]  ncl;
  logic [7:0]  dsh;
  logic [29:0] fr, av;
  logic        fsw;
  logic [30:0] qt, qc;
  logic [34:0] qrem;
  logic signed [33:0] term;
  logic [30:0] sc, cc, s_e, c_e, mag;
  logic signed [31:0] trig;
  logic signed [31:0] ctr;
  logic [64:0] rnd;
  logic [33:0] off;
  logic signed [35:0] vsum;
  logic signed [31:0] vsat;
  logic        is_last, load;
  logic [7:0]  prem_s;

  // clamp of the vertex count
  always_comb begin
    if (seg_count == 7'd0) ncl = 7'd1;
    else if (seg_count > MaxSeg) ncl = MaxSeg;
    else ncl = seg_count;
  end

  assign dsh = {drem_r[6:0], (dcnt_r == 6'd32)};
  assign fr = phase_r[29:0];
  assign fsw = fr > 30'h2000_0000;
  assign av = fsw ? 30'(31'h4000_0000 - 31'(fr)) : fr;

  // quotient from reciprocal, then one correction step
  assign qt = prod_r[62:32];
  assign qrem = 35'(u_r) - 35'(qt) * 35'(k_r);
  assign qc = (qrem >= 35'(k_r)) ? qt + 31'd1 : qt;
  assign term = k_r[1] ? -34'(qc) : 34'(qc);

  always_comb begin
    if (sn_r < 0) sc = '0;
    else if (sn_r > 34'sh4000_0000) sc = 31'h4000_0000;
    else sc = 31'(sn_r);
    if (cs_r < 0) cc = '0;
    else if (cs_r > 34'sh4000_0000) cc = 31'h4000_0000;
    else cc = 31'(cs_r);
    s_e = swap_r ? cc : sc;
    c_e = swap_r ? sc : cc;
  end

  assign trig = (state_r == cvg_pkg::B_PX || state_r == cvg_pkg::B_FX) ? vc_r : vs_r;
  assign mag = trig[31] ? 31'(-trig) : 31'(trig);
  assign ctr = (state_r == cvg_pkg::B_FX) ? cx_r : cy_r;
  assign rnd = 65'(prod_r) + 65'h2000_0000;
  assign off = rnd[63:30];

  always_comb begin
    vsum = (trig[31] ? -36'(off) : 36'(off)) + 36'(ctr);
    if (vsum > 36'sh7FFF_FFFF) vsat = 32'sh7FFF_FFFF;
    else if (vsum < -36'sh8000_0000) vsat = -32'sh8000_0000;
    else vsat = 32'(vsum);
  end

  assign is_last = (7'(i_r) == n_r - 7'd1);
  assign load = (state_r == cvg_pkg::B_OUT) && (!out_valid_r || out_ready);
  assign prem_s = 8'(prem_r) + 8'(drem_r[6:0]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cvg_pkg::B_IDLE:  if (!empty) state_nxt = cvg_pkg::B_DIV;
      cvg_pkg::B_DIV:   if (dcnt_r == 6'd0) state_nxt = cvg_pkg::B_VSET;
      cvg_pkg::B_VSET:  state_nxt = cvg_pkg::B_XS;
      cvg_pkg::B_XS:    state_nxt = cvg_pkg::B_TA;
      cvg_pkg::B_TA:    state_nxt = cvg_pkg::B_TB;
      cvg_pkg::B_TB:    state_nxt = cvg_pkg::B_TC;
      cvg_pkg::B_TC:
        state_nxt = (k_r == cvg_pkg::LastTerm) ? cvg_pkg::B_CLAMP : cvg_pkg::B_TA;
      cvg_pkg::B_CLAMP: state_nxt = cvg_pkg::B_PX;
      cvg_pkg::B_PX:    state_nxt = cvg_pkg::B_FX;
      cvg_pkg::B_FX:    state_nxt = cvg_pkg::B_PY;
      cvg_pkg::B_PY:    state_nxt = cvg_pkg::B_FY;
      cvg_pkg::B_FY:    state_nxt = cvg_pkg::B_OUT;
      cvg_pkg::B_OUT:
        if (load) state_nxt = is_last ? cvg_pkg::B_IDLE : cvg_pkg::B_VSET;
      default: state_nxt = cvg_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state_r == cvg_pkg::B_IDLE) && !empty;
    out_valid = out_valid_r;
    vertex_x = out_x_r;
    vertex_y = out_y_r;
    last_vertex = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cvg_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r <= vx_r;
      out_y_r <= vsat;
      out_last_r <= is_last;
    end
    unique case (state_r)
      cvg_pkg::B_IDLE: begin
        cx_r <= head.cx;
        cy_r <= head.cy;
        r_r <= head.r;
        n_r <= ncl;
        drem_r <= '0;
        dq_r <= '0;
        dcnt_r <= 6'd32;
      end
      cvg_pkg::B_DIV: begin
        // 2^32 / n, one quotient bit per cycle
        if (dsh >= {1'b0, n_r}) begin
          drem_r <= dsh - {1'b0, n_r};
          dq_r <= {dq_r[31:0], 1'b1};
        end else begin
          drem_r <= dsh;
          dq_r <= {dq_r[31:0], 1'b0};
        end
        if (dcnt_r != 6'd0) dcnt_r <= dcnt_r - 6'd1;
        i_r <= '0;
        phase_r <= '0;
        prem_r <= '0;
      end
      cvg_pkg::B_VSET: begin
        swap_r <= fsw;
        quad_r <= phase_r[31:30];
        prod_r <= 64'(av) * 64'(cvg_pkg::PiQ30);
      end
      cvg_pkg::B_XS: begin
        x_r <= prod_r[61:31];
        t_r <= 31'h4000_0000;
        k_r <= 4'd1;
        sn_r <= '0;
        cs_r <= 34'sh4000_0000;
      end
      cvg_pkg::B_TA: prod_r <= 64'(t_r) * 64'(x_r);
      cvg_pkg::B_TB: begin
        u_r <= prod_r[60:30];
        prod_r <= 64'(prod_r[60:30]) * 64'(cvg_pkg::recip(k_r));
      end
      cvg_pkg::B_TC: begin
        t_r <= qc;
        if (k_r[0]) sn_r <= sn_r + term;
        else cs_r <= cs_r + term;
        k_r <= k_r + 4'd1;
      end
      cvg_pkg::B_CLAMP: begin
        unique case (quad_r)
          2'd0: begin vc_r <= 32'(c_e); vs_r <= 32'(s_e); end
          2'd1: begin vc_r <= -32'(s_e); vs_r <= 32'(c_e); end
          2'd2: begin vc_r <= -32'(c_e); vs_r <= -32'(s_e); end
          default: begin vc_r <= 32'(s_e); vs_r <= -32'(c_e); end
        endcase
      end
      cvg_pkg::B_PX, cvg_pkg::B_PY: prod_r <= 64'(r_r) * 64'(mag);
      cvg_pkg::B_FX: vx_r <= vsat;
      cvg_pkg::B_OUT: begin
        if (load) begin
          i_r <= i_r + IW'(1);
          // phase steps by the quotient, remainder carries over
          if (prem_s >= {1'b0, n_r}) begin
            phase_r <= phase_r + dq_r + 33'd1;
            prem_r <= 7'(prem_s - {1'b0, n_r});
          end else begin
            phase_r <= phase_r + dq_r;
            prem_r <= prem_s[6:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/circle_vertex_generator.sv
// front: 33 square steps, then 33 root steps per circle; the back then
// divides the full turn by the clamped vertex count, bit by bit
// the front takes a new circle once the last is queued; the back takes one
// circle at a time, each vertex from a 13-term sin/cos series
// reset: synchronous active-low, clears control, queue and output valid;
// the vertex count returns to 12
`timescale 1ns / 1ps
module circle_vertex_generator #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x, center_y, rim_x, rim_y
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vertex_x, vertex_y
  output logic [63:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  logic [6:0] seg_r;
  logic push, full, pop, empty;
  cvg_pkg::cvg_job_t push_job, head;
  logic [31:0] vx, vy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= cvg_pkg::SegReset;
    end else if (cfg_we) begin
      seg_r <= cfg_wdata;
    end
  end

  cvg_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .center_x(in_tdata[31:0]), .center_y(in_tdata[63:32]),
    .rim_x(in_tdata[95:64]), .rim_y(in_tdata[127:96]),
    .push(push), .push_job(push_job), .fifo_full(full)
  );

  cvg_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_job(push_job), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  cvg_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
    .clk(clk), .rst_n(rst_n), .seg_count(seg_r),
    .empty(empty), .head(head), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .vertex_x(vx), .vertex_y(vy), .last_vertex(out_tlast)
  );

  assign out_tdata = {vy, vx};

endmodule

>>> rtl/cvg_checker.sv
`timescale 1ns / 1ps
`include "circle_vertex_generator_macros.svh"
module cvg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [127:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic         out_tlast,
  input logic         cfg_we,
  input logic [6:0]   cfg_wdata
);

  // a stalled result keeps its valid and its payload
  `CVG_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `CVG_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
  // the front is busy with a circle right after taking a request
  `CVG_ASSERT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  // nothing comes out of reset
  `CVG_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid)

endmodule

bind circle_vertex_generator cvg_checker u_cvg_checker (.*);
